// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/qrs_pkg.sv =====
package qrs_pkg;

  localparam int W = 32;
  localparam int FRAC = 16;
  localparam int D_W = 66;
  localparam int R_W = 33;
  localparam int REM_W = 37;
  localparam int SQ_STEPS = 33;
  localparam int N_W = 34;
  localparam int Q_W = 50;
  localparam int DEN_W = 33;
  localparam int DV_STEPS = 50;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NEG_DISC = 2'd1;
  localparam logic [1:0] ST_ZERO_QUAD = 2'd2;

  typedef struct packed {
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic         sa;
    logic         sb;
    logic [1:0]   st;
  } sq_side_t;

  typedef struct packed {
    logic             vld;
    logic [D_W-1:0]   d;
    logic [R_W-1:0]   root;
    logic [REM_W-1:0] rem;
    sq_side_t         side;
  } sq_data_t;

  typedef struct packed {
    logic             vld;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   np;
    logic [Q_W-1:0]   nm;
    logic [DEN_W-1:0] rp;
    logic [DEN_W-1:0] rm;
    logic [Q_W-1:0]   qp;
    logic [Q_W-1:0]   qm;
    logic             negp;
    logic             negm;
    logic [1:0]       st;
  } dv_data_t;

endpackage

// ===== design/qrs_sqrt_cell.sv =====
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  sq_data_t cur,
  output sq_data_t q
);

  logic [REM_W-1:0] rem_s;
  logic [REM_W-1:0] trial;
  logic             ge;
  sq_data_t         q_next;

  always_comb begin
    rem_s = {cur.rem[REM_W-3:0], cur.d[D_W-1:D_W-2]};
    trial = {2'b00, cur.root, 2'b01};
    ge = (rem_s >= trial);
    q_next = cur;
    q_next.rem = ge ? (rem_s - trial) : rem_s;
    q_next.root = {cur.root[R_W-2:0], ge};
    q_next.d = {cur.d[D_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== design/qrs_div_cell.sv =====
module qrs_div_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  dv_data_t cur,
  output dv_data_t q
);

  logic [DEN_W:0] dx;
  logic [DEN_W:0] sp;
  logic [DEN_W:0] sm;
  logic           gep;
  logic           gem;
  logic [DEN_W:0] dp;
  logic [DEN_W:0] dm;
  dv_data_t       q_next;

  always_comb begin
    dx = {1'b0, cur.den};
    sp = {cur.rp, cur.np[Q_W-1]};
    sm = {cur.rm, cur.nm[Q_W-1]};
    gep = (sp >= dx);
    gem = (sm >= dx);
    dp = gep ? (sp - dx) : sp;
    dm = gem ? (sm - dx) : sm;
    q_next = cur;
    q_next.rp = dp[DEN_W-1:0];
    q_next.rm = dm[DEN_W-1:0];
    q_next.np = {cur.np[Q_W-2:0], 1'b0};
    q_next.nm = {cur.nm[Q_W-2:0], 1'b0};
    q_next.qp = {cur.qp[Q_W-2:0], gep};
    q_next.qm = {cur.qm[Q_W-2:0], gem};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== design/quadratic_root_solver.sv =====
// Quadratic root solver for a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// Requests enter on in_valid/in_ready carrying coef_quad, coef_lin and
// coef_const; results leave on out_valid/out_ready carrying root_plus,
// root_minus and status (0 roots valid, 1 negative discriminant, 2 a is zero).
// The datapath is one pipeline: split and multiply, discriminant, a row of
// 33 square-root cells that each resolve one root bit, the signed numerators,
// and a row of 50 divider cells that each resolve one quotient bit of both
// roots, followed by saturation into the output register.
// One request is taken every cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps moving until its last stage holds a finished result; only
// then does in_ready fall. Results come out in request order.
// Reset clears every valid bit; the pipeline is then empty and ready.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] coef_quad,
  input  logic signed [W-1:0] coef_lin,
  input  logic signed [W-1:0] coef_const,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] root_plus,
  output logic signed [W-1:0] root_minus,
  output logic [1:0]          status
);

  logic en;

  logic         a_vld;
  logic [W-1:0] a_ma;
  logic [W-1:0] a_mb;
  logic [W-1:0] a_mc;
  logic         a_sa;
  logic         a_sb;
  logic         a_sc;

  logic          b_vld;
  logic [63:0]   b_b2;
  logic [63:0]   b_pm;
  logic [W-1:0]  b_ma;
  logic [W-1:0]  b_mb;
  logic          b_sa;
  logic          b_sb;
  logic          b_sc;

  sq_data_t sq [SQ_STEPS+1];
  sq_data_t c_next;
  dv_data_t dv [DV_STEPS+1];
  dv_data_t e_next;

  logic [D_W-1:0] b2x;
  logic [D_W-1:0] p4;

  logic [N_W-1:0] mbx;
  logic [N_W-1:0] rx;
  logic           sp_sign;
  logic           sm_sign;
  logic [N_W-1:0] np_mag;
  logic [N_W-1:0] nm_mag;

  logic [Q_W-1:0] lim_p;
  logic [Q_W-1:0] lim_m;
  logic [Q_W-1:0] mag_p;
  logic [Q_W-1:0] mag_m;
  logic [W-1:0]   val_p;
  logic [W-1:0]   val_m;

  assign en = !out_valid || out_ready || !dv[DV_STEPS].vld;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      a_sa <= coef_quad[W-1];
      a_sb <= coef_lin[W-1];
      a_sc <= coef_const[W-1];
      a_ma <= coef_quad[W-1] ? W'(-coef_quad) : coef_quad;
      a_mb <= coef_lin[W-1] ? W'(-coef_lin) : coef_lin;
      a_mc <= coef_const[W-1] ? W'(-coef_const) : coef_const;
      b_vld <= a_vld;
      b_b2 <= 64'(a_mb) * 64'(a_mb);
      b_pm <= 64'(a_ma) * 64'(a_mc);
      b_ma <= a_ma;
      b_mb <= a_mb;
      b_sa <= a_sa;
      b_sb <= a_sb;
      b_sc <= a_sc;
    end
  end

  always_comb begin
    b2x = {2'b00, b_b2};
    p4 = {b_pm, 2'b00};
    c_next.vld = b_vld;
    c_next.root = '0;
    c_next.rem = '0;
    c_next.side.ma = b_ma;
    c_next.side.mb = b_mb;
    c_next.side.sa = b_sa;
    c_next.side.sb = b_sb;
    c_next.side.st = ST_OK;
    c_next.d = '0;
    if (b_ma == '0) begin
      c_next.side.st = ST_ZERO_QUAD;
    end else if (b_sa != b_sc) begin
      c_next.d = b2x + p4;
    end else if (b2x < p4) begin
      c_next.side.st = ST_NEG_DISC;
    end else begin
      c_next.d = b2x - p4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].vld <= 1'b0;
    end else if (en) begin
      sq[0] <= c_next;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .cur (sq[i]),
      .q   (sq[i+1])
    );
  end

  always_comb begin
    mbx = N_W'(sq[SQ_STEPS].side.mb);
    rx = N_W'(sq[SQ_STEPS].root);
    // Plus root: (-b) + r. Minus root: (-b) - r. Sign-magnitude sums.
    if (sq[SQ_STEPS].side.sb) begin
      np_mag = mbx + rx;
      sp_sign = 1'b0;
    end else if (mbx >= rx) begin
      np_mag = mbx - rx;
      sp_sign = 1'b1;
    end else begin
      np_mag = rx - mbx;
      sp_sign = 1'b0;
    end
    if (!sq[SQ_STEPS].side.sb) begin
      nm_mag = mbx + rx;
      sm_sign = 1'b1;
    end else if (mbx >= rx) begin
      nm_mag = mbx - rx;
      sm_sign = 1'b0;
    end else begin
      nm_mag = rx - mbx;
      sm_sign = 1'b1;
    end
    e_next.vld = sq[SQ_STEPS].vld;
    e_next.den = {sq[SQ_STEPS].side.ma, 1'b0};
    e_next.np = {np_mag, {FRAC{1'b0}}};
    e_next.nm = {nm_mag, {FRAC{1'b0}}};
    e_next.rp = '0;
    e_next.rm = '0;
    e_next.qp = '0;
    e_next.qm = '0;
    e_next.negp = sp_sign ^ sq[SQ_STEPS].side.sa;
    e_next.negm = sm_sign ^ sq[SQ_STEPS].side.sa;
    e_next.st = sq[SQ_STEPS].side.st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].vld <= 1'b0;
    end else if (en) begin
      dv[0] <= e_next;
    end
  end

  for (genvar i = 0; i < DV_STEPS; i++) begin : g_div
    qrs_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .cur (dv[i]),
      .q   (dv[i+1])
    );
  end

  always_comb begin
    lim_p = dv[DV_STEPS].negp ? (Q_W'(1) << (W-1)) : ((Q_W'(1) << (W-1)) - Q_W'(1));
    lim_m = dv[DV_STEPS].negm ? (Q_W'(1) << (W-1)) : ((Q_W'(1) << (W-1)) - Q_W'(1));
    mag_p = (dv[DV_STEPS].qp > lim_p) ? lim_p : dv[DV_STEPS].qp;
    mag_m = (dv[DV_STEPS].qm > lim_m) ? lim_m : dv[DV_STEPS].qm;
    val_p = dv[DV_STEPS].negp ? (W'(0) - mag_p[W-1:0]) : mag_p[W-1:0];
    val_m = dv[DV_STEPS].negm ? (W'(0) - mag_m[W-1:0]) : mag_m[W-1:0];
    if (dv[DV_STEPS].st != ST_OK) begin
      val_p = '0;
      val_m = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= dv[DV_STEPS].vld;
      root_plus <= val_p;
      root_minus <= val_m;
      status <= dv[DV_STEPS].st;
    end
  end

endmodule

// ===== design/qrs_checker.sv =====
`include "assert_macros.svh"

module qrs_checker import qrs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] root_plus,
  input logic signed [W-1:0] root_minus,
  input logic [1:0]          status
);

  logic stalled;

  assign stalled = out_valid && !out_ready;

  `QRS_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(root_plus) && $stable(root_minus) && $stable(status))
  `QRS_ASSERT_NOW(a_ready_only_on_stall, !in_ready, stalled)
  `QRS_ASSERT_NOW(a_status_code, out_valid, status == ST_OK || status == ST_NEG_DISC || status == ST_ZERO_QUAD)
  `QRS_ASSERT_NOW(a_flagged_zero, out_valid && status != ST_OK, root_plus == '0 && root_minus == '0)

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

// ===== tb/sv/tb_quadratic_root_solver.sv =====
`timescale 1ns / 100ps

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int N_RANDOM = 450;
  localparam int LATENCY = 87;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [W-1:0] rp;
    logic signed [W-1:0] rm;
    logic [1:0]          st;
  } roots_t;

  typedef struct {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] c;
    bit           typed;
    roots_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] coef_quad = '0;
  logic signed [W-1:0] coef_lin = '0;
  logic signed [W-1:0] coef_const = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] root_plus;
  logic signed [W-1:0] root_minus;
  logic [1:0] status;

  roots_t expected_roots[$];
  int mismatch_count = 0;
  longint cycle_count = 0;
  bit stimulus_done = 0;
  bit hold_active = 0;

  quadratic_root_solver dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quadratic_root_solver verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // One root: ((-B +/- R) << FRAC) / (2A), truncated toward zero, saturated.
  function automatic logic [W-1:0] solve_root(input logic signed [67:0] numer,
                                              input logic signed [W-1:0] a);
    logic [67:0] nmag;
    logic [99:0] shifted;
    logic [99:0] q;
    logic [33:0] den;
    bit neg;
    logic [99:0] lim;
    nmag = numer[67] ? -numer : numer;
    den = a[W-1] ? 34'(-{{2{a[W-1]}}, a}) << 1 : 34'({2'b0, a}) << 1;
    neg = numer[67] ^ a[W-1];
    shifted = {32'b0, nmag} << FRAC;
    q = shifted / {66'b0, den};
    lim = neg ? 100'h80000000 : 100'h7fffffff;
    if (q > lim) q = lim;
    return neg ? W'(-q) : W'(q);
  endfunction

  function automatic roots_t solve_quadratic(input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b,
                                             input logic signed [W-1:0] c);
    roots_t r;
    logic signed [67:0] disc;
    logic [67:0] rt;
    logic [67:0] rem;
    logic [67:0] trial;
    r.rp = '0;
    r.rm = '0;
    if (a == 0) begin
      r.st = ST_ZERO_QUAD;
      return r;
    end
    disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
    if (disc < 0) begin
      r.st = ST_NEG_DISC;
      return r;
    end
    rt = '0;
    rem = '0;
    for (int p = 33; p >= 0; p--) begin
      rem = (rem << 2) | ((disc >> (2 * p)) & 3);
      trial = (rt << 2) | 1;
      rt = rt << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        rt = rt | 1;
      end
    end
    r.rp = solve_root(-68'(b) + $signed(rt), a);
    r.rm = solve_root(-68'(b) - $signed(rt), a);
    r.st = ST_OK;
    return r;
  endfunction

  task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] b,
                              input logic [W-1:0] c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    coef_quad <= a;
    coef_lin <= b;
    coef_const <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_roots.push_back(solve_quadratic(a, b, c));
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] pick_value(input int kind);
    case (kind)
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 1) ? 32'(-$urandom_range(1, 32'h3ffff))
                                     : 32'($urandom_range(1, 32'h3ffff));
      3: return $urandom_range(0, 1) ? 32'(-$urandom_range(1, 32'h0ff))
                                     : 32'($urandom_range(1, 32'h0ff));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    roots_t z;
    z.rp = '0;
    z.rm = '0;
    z.st = ST_ZERO_QUAD;
    rows.push_back('{32'h0, 32'h7fffffff, 32'h12345, 1, z});
    rows.push_back('{32'h0, 32'h80000000, 32'h80000000, 1, z});
    z.st = ST_NEG_DISC;
    rows.push_back('{32'h10000, 32'h0, 32'h10000, 1, z});
    rows.push_back('{32'h7fffffff, 32'h0, 32'h7fffffff, 1, z});
    rows.push_back('{32'h80000000, 32'h0, 32'h80000000, 1, z});
    z.st = ST_OK;
    z.rp = 32'h10000;
    z.rm = 32'hffff0000;
    rows.push_back('{32'h10000, 32'h0, 32'hffff0000, 1, z});
    z.rp = '0;
    z.rm = '0;
    rows.push_back('{32'h10000, 32'h0, 32'h0, 1, z});
    rows.push_back('{32'h10000, 32'hfffd0000, 32'h20000, 0, z});
    rows.push_back('{32'h1, 32'h7fffffff, 32'h0, 0, z});
    rows.push_back('{32'h1, 32'h80000000, 32'h80000000, 0, z});
    rows.push_back('{32'hffffffff, 32'h7fffffff, 32'h7fffffff, 0, z});
    rows.push_back('{32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, z});
    rows.push_back('{32'h80000000, 32'h80000000, 32'h7fffffff, 0, z});
    rows.push_back('{32'h7fffffff, 32'h80000000, 32'h80000000, 0, z});
    rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, z});
    rows.push_back('{32'hffffffff, 32'h0, 32'h1, 0, z});
    rows.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, z});
    rows.push_back('{32'h20000, 32'h40000, 32'h20000, 0, z});
    rows.push_back('{32'hfffe0000, 32'h10000, 32'h30000, 0, z});
    rows.push_back('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 0, z});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.typed) begin
        z = solve_quadratic(row.a, row.b, row.c);
        if (z.st != row.want.st || z.rp != row.want.rp || z.rm != row.want.rm)
          report_mismatch("table row", {z.rp[W-3:0], z.st}, {row.want.rp[W-3:0], row.want.st});
      end
      send_request(row.a, row.b, row.c);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) hold_active = 1;
      send_request(pick_value($urandom_range(0, 4) == 0 ? $urandom_range(0, 1)
                                                         : $urandom_range(2, 4)),
                   pick_value($urandom_range(0, 4)),
                   pick_value($urandom_range(0, 4)));
    end
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_active) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_active = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    roots_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected result", status, 'x);
      end else begin
        w = expected_roots.pop_front();
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (root_plus !== w.rp) report_mismatch("root_plus", root_plus, w.rp);
        if (root_minus !== w.rm) report_mismatch("root_minus", root_minus, w.rm);
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("quadratic_root_solver verification clean");
    end else begin
      $display("quadratic_root_solver verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver.sv
design/qrs_checker.sv
tb/sv/tb_quadratic_root_solver.sv
